FILE: rtl/variable_width_adpcm_decoder_defines.svh
// Assertion macros for the variable-width ADPCM decoder.
// Used by variable_width_adpcm_decoder.sv; expects clk and rst_n in scope.
`ifndef VARIABLE_WIDTH_ADPCM_DECODER_DEFINES_SVH
`define VARIABLE_WIDTH_ADPCM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define VWAD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vwad assertion failed");

// antecedent implies consequent in the next cycle
`define VWAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vwad assertion failed");

`else

`define VWAD_ASSERT_SAME(label, ante, cons)
`define VWAD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/vwad_pkg.sv
// Shared types, constants and step table for the variable-width ADPCM decoder.
// No dependencies.
package vwad_pkg;

    localparam logic [6:0] IDX_MAX      = 7'd79;
    localparam logic [6:0] IDX_WIDE_MIN = 7'd18;
    localparam logic [6:0] IDX_RESET    = 7'd40;
    localparam logic signed [16:0] PRED_MIN = -17'sd2048;
    localparam logic signed [16:0] PRED_MAX = 17'sd2047;

    // one code handed to the difference unit
    typedef struct packed {
        logic [6:0] cur_idx;
        logic [3:0] code;
        logic       wide;
    } code_req_t;

    function automatic logic [13:0] step_size(input logic [6:0] idx);
        logic [13:0] s;
        unique case (idx)
            7'd0:  s = 14'd7;     7'd1:  s = 14'd8;     7'd2:  s = 14'd9;
            7'd3:  s = 14'd10;    7'd4:  s = 14'd11;    7'd5:  s = 14'd12;
            7'd6:  s = 14'd13;    7'd7:  s = 14'd14;    7'd8:  s = 14'd16;
            7'd9:  s = 14'd17;    7'd10: s = 14'd19;    7'd11: s = 14'd21;
            7'd12: s = 14'd23;    7'd13: s = 14'd25;    7'd14: s = 14'd28;
            7'd15: s = 14'd31;    7'd16: s = 14'd34;    7'd17: s = 14'd37;
            7'd18: s = 14'd41;    7'd19: s = 14'd45;    7'd20: s = 14'd50;
            7'd21: s = 14'd55;    7'd22: s = 14'd60;    7'd23: s = 14'd66;
            7'd24: s = 14'd73;    7'd25: s = 14'd80;    7'd26: s = 14'd88;
            7'd27: s = 14'd97;    7'd28: s = 14'd107;   7'd29: s = 14'd118;
            7'd30: s = 14'd130;   7'd31: s = 14'd143;   7'd32: s = 14'd157;
            7'd33: s = 14'd173;   7'd34: s = 14'd190;   7'd35: s = 14'd209;
            7'd36: s = 14'd230;   7'd37: s = 14'd253;   7'd38: s = 14'd279;
            7'd39: s = 14'd307;   7'd40: s = 14'd337;   7'd41: s = 14'd371;
            7'd42: s = 14'd408;   7'd43: s = 14'd449;   7'd44: s = 14'd494;
            7'd45: s = 14'd544;   7'd46: s = 14'd598;   7'd47: s = 14'd658;
            7'd48: s = 14'd724;   7'd49: s = 14'd796;   7'd50: s = 14'd876;
            7'd51: s = 14'd963;   7'd52: s = 14'd1060;  7'd53: s = 14'd1166;
            7'd54: s = 14'd1282;  7'd55: s = 14'd1411;  7'd56: s = 14'd1552;
            7'd57: s = 14'd1707;  7'd58: s = 14'd1878;  7'd59: s = 14'd2066;
            7'd60: s = 14'd2272;  7'd61: s = 14'd2499;  7'd62: s = 14'd2749;
            7'd63: s = 14'd3024;  7'd64: s = 14'd3327;  7'd65: s = 14'd3660;
            7'd66: s = 14'd4026;  7'd67: s = 14'd4428;  7'd68: s = 14'd4871;
            7'd69: s = 14'd5358;  7'd70: s = 14'd5894;  7'd71: s = 14'd6484;
            7'd72: s = 14'd7132;  7'd73: s = 14'd7845;  7'd74: s = 14'd8630;
            7'd75: s = 14'd9493;  7'd76: s = 14'd10442; 7'd77: s = 14'd11487;
            7'd78: s = 14'd12635; 7'd79: s = 14'd13899;
            default: s = 14'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/variable_width_adpcm_decoder.sv
// Top level of the variable-width ADPCM decoder: sequencer, predictor, output register.
// Depends on vwad_pkg, vwad_diff_unit and variable_width_adpcm_decoder_defines.svh.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   data_byte, first_of_track
//  output    out        out_valid / out_stall pcm_sample, last_of_byte
//  config    in         cfg_valid / cfg_ready cfg_data (initial_step_index)
//
// Each code passes through S_DIFF, in the difference unit, then S_APPLY, in the
// predictor adder and clamp, which waits while the output is stalled. A byte holds
// 2 to 4 codes.
// in_stall is high while a byte is being decoded. Reset clears the predictor
// and loads step index 40; cfg_ready is always high.
module variable_width_adpcm_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               first_of_track,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pcm_sample,
    output logic               last_of_byte,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data
);
    import vwad_pkg::*;

    `include "variable_width_adpcm_decoder_defines.svh"

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIFF  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [6:0]         init_idx_reg, init_idx_next;
    logic [6:0]         idx_reg, idx_next;
    logic signed [11:0] pred_reg, pred_next;
    logic [7:0]         bits_reg, bits_next;
    logic [3:0]         pos_reg, pos_next;
    logic               last_reg, last_next;
    logic signed [15:0] diff_reg, diff_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] sample_reg, sample_next;
    logic               out_last_reg, out_last_next;

    code_req_t          req;
    logic signed [15:0] unit_diff;
    logic [6:0]         unit_idx;
    logic               wide;
    logic               out_free;
    logic               in_take;
    logic signed [16:0] sum;
    logic [6:0]         load_idx;

    vwad_diff_unit u_diff (
        .req        (req),
        .diff       (unit_diff),
        .index_next (unit_idx)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign pcm_sample = sample_reg;
    assign last_of_byte = out_last_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // 4-bit code unless index is low or only two bits remain
    assign wide = (idx_reg >= IDX_WIDE_MIN) && (pos_reg <= 4'd4);
    assign load_idx = (init_idx_reg > IDX_MAX) ? IDX_MAX : init_idx_reg;

    always_comb
    begin
        req.cur_idx = idx_reg;
        req.wide    = wide;
        req.code    = wide ? bits_reg[3:0] : {2'b00, bits_reg[1:0]};
        sum = $signed({{5{pred_reg[11]}}, pred_reg}) + $signed({diff_reg[15], diff_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        init_idx_next  = (cfg_valid && cfg_ready) ? cfg_data : init_idx_reg;
        idx_next       = idx_reg;
        pred_next      = pred_reg;
        bits_next      = bits_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        diff_next      = diff_reg;
        sample_next    = sample_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (first_of_track)
                    begin
                        pred_next = 12'sd0;
                        idx_next  = load_idx;
                    end
                    bits_next  = data_byte;
                    pos_next   = 4'd0;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                diff_next  = unit_diff;
                idx_next   = unit_idx;
                bits_next  = wide ? (bits_reg >> 4) : (bits_reg >> 2);
                pos_next   = pos_reg + (wide ? 4'd4 : 4'd2);
                last_next  = pos_next[3];
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    priority if (sum < PRED_MIN)
                        pred_next = PRED_MIN[11:0];
                    else if (sum > PRED_MAX)
                        pred_next = PRED_MAX[11:0];
                    else
                        pred_next = sum[11:0];
                    sample_next    = {pred_next, 4'b0000};
                    out_last_next  = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = last_reg ? S_IDLE : S_DIFF;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_idx_reg  <= IDX_RESET;
            idx_reg       <= IDX_RESET;
            pred_reg      <= 12'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_idx_reg  <= init_idx_next;
            idx_reg       <= idx_next;
            pred_reg      <= pred_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg     <= bits_next;
        pos_reg      <= pos_next;
        last_reg     <= last_next;
        diff_reg     <= diff_next;
        sample_reg   <= sample_next;
        out_last_reg <= out_last_next;
    end

    `VWAD_ASSERT_SAME(a_idx_range, 1'b1, idx_reg <= IDX_MAX)
    `VWAD_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_reg == S_DIFF)
    `VWAD_ASSERT_NEXT(a_apply_emits, (state_reg == S_APPLY) && out_free, out_valid_reg)

endmodule

FILE: rtl/vwad_diff_unit.sv
// Difference and step-index update for one ADPCM code (2- or 4-bit).
// Depends on vwad_pkg.
module vwad_diff_unit (
    input  vwad_pkg::code_req_t  req,
    output logic signed [15:0]   diff,
    output logic [6:0]           index_next
);
    import vwad_pkg::*;

    logic [13:0] step;
    logic [14:0] mag;
    logic        neg;
    logic        dec;
    logic [7:0]  inc;
    logic [7:0]  idx_up;

    always_comb
    begin
        step = step_size(req.cur_idx);
        mag  = {4'b0, step[13:3]};
        if (req.wide)
        begin
            if (req.code[0]) mag = mag + {3'b0, step[13:2]};
            if (req.code[1]) mag = mag + {2'b0, step[13:1]};
            if (req.code[2]) mag = mag + {1'b0, step};
            neg = req.code[3];
            dec = !req.code[2];
            // +2,+4,+6,+8 from the low two bits
            inc = {5'b0, req.code[1:0], 1'b0} + 8'd2;
        end
        else
        begin
            if (req.code[0]) mag = mag + {1'b0, step};
            neg = req.code[1];
            dec = !req.code[0];
            inc = 8'd2;
        end
        diff = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        idx_up = {1'b0, req.cur_idx} + inc;
        if (dec)
            index_next = (req.cur_idx == 7'd0) ? 7'd0 : req.cur_idx - 7'd1;
        else
            index_next = (idx_up > {1'b0, IDX_MAX}) ? IDX_MAX : idx_up[6:0];
    end

endmodule

FILE: bench/variable_width_adpcm_decoder_tb.sv
// Testbench for variable_width_adpcm_decoder: byte stream in, PCM samples out, checked
// against an in-bench IMA-style decoder model. Depends on vwad_pkg and the decoder RTL.
module variable_width_adpcm_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vwad_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } adpcm_byte_t;

    typedef struct {
        logic signed [15:0] pcm;
        logic               eob;
    } pcm_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'h00;
    logic               first_of_track = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] pcm_sample;
    logic               last_of_byte;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [6:0]         cfg_data = 7'd0;

    variable_width_adpcm_decoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .first_of_track (first_of_track),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pcm_sample     (pcm_sample),
        .last_of_byte   (last_of_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    int step_lut [80] = '{
        7, 8, 9, 10, 11, 12, 13, 14, 16, 17,
        19, 21, 23, 25, 28, 31, 34, 37, 41, 45,
        50, 55, 60, 66, 73, 80, 88, 97, 107, 118,
        130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
        337, 371, 408, 449, 494, 544, 598, 658, 724, 796,
        876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066,
        2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358,
        5894, 6484, 7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899
    };

    // decoder model state and its copy of the start-index register
    logic [6:0]  start_idx = IDX_RESET;
    int          pred_val = 0;
    int          step_idx = int'(IDX_RESET);

    adpcm_byte_t pending_bytes_q[$];
    pcm_result_t expected_pcm_q[$];
    int          bytes_outstanding = 0;
    int          bytes_decoded = 0;
    int          samples_checked = 0;
    int          index_writes = 0;
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Decode one byte into the expected sample queue, advancing the model state.
    function automatic void decode_byte(input logic [7:0] b, input logic first);
        int          stp;
        int          diff;
        int          nidx;
        int          pos;
        logic [7:0]  bits;
        logic [3:0]  code;
        pcm_result_t r;
        bits = b;
        pos = 0;
        if (first)
        begin
            pred_val = 0;
            step_idx = (start_idx > IDX_MAX) ? int'(IDX_MAX) : int'(start_idx);
        end
        while (pos < 8)
        begin
            stp = step_lut[step_idx];
            diff = stp >>> 3;
            // narrow code at low index, or when only two bits are left
            if (step_idx < int'(IDX_WIDE_MIN) || pos > 4)
            begin
                code = {2'b00, bits[1:0]};
                if (code[0])
                    diff += stp;
                if (code[1])
                    diff = -diff;
                nidx = step_idx + (code[0] ? 2 : -1);
                bits = bits >> 2;
                pos += 2;
            end
            else
            begin
                code = bits[3:0];
                if (code[0])
                    diff += stp >>> 2;
                if (code[1])
                    diff += stp >>> 1;
                if (code[2])
                    diff += stp;
                if (code[3])
                    diff = -diff;
                nidx = step_idx + (code[2] ? 2 * (int'(code[1:0]) + 1) : -1);
                bits = bits >> 4;
                pos += 4;
            end
            step_idx = clamp_int(nidx, 0, int'(IDX_MAX));
            pred_val = clamp_int(pred_val + diff, int'(PRED_MIN), int'(PRED_MAX));
            r.pcm = 16'(pred_val * 16);
            r.eob = (pos >= 8);
            expected_pcm_q.insert(expected_pcm_q.size(), r);
        end
    endfunction

    // Byte driver: presents queued bytes, holds them while stalled.
    always @(posedge clk)
    begin : drive_bytes
        logic        nxt_valid;
        adpcm_byte_t nxt;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            nxt.data = data_byte;
            nxt.first = first_of_track;
            if (in_valid && !in_stall)
            begin
                decode_byte(data_byte, first_of_track);
                bytes_decoded++;
                bytes_outstanding--;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_bytes_q.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_bytes_q.pop_front();
                nxt_valid = 1'b1;
            end
            in_valid <= nxt_valid;
            data_byte <= nxt.data;
            first_of_track <= nxt.first;
        end
    end

    // Sample monitor and output backpressure.
    always @(posedge clk)
    begin : check_samples
        pcm_result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                samples_checked++;
                if (expected_pcm_q.size() == 0)
                begin
                    $display("%0t: unexpected sample, expected none, got pcm %0d last %0b",
                             $time, pcm_sample, last_of_byte);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_pcm_q.pop_front();
                    if (pcm_sample !== exp_r.pcm)
                    begin
                        $display("%0t: pcm_sample mismatch, expected %0d, got %0d",
                                 $time, exp_r.pcm, pcm_sample);
                        error_count++;
                    end
                    if (last_of_byte !== exp_r.eob)
                    begin
                        $display("%0t: last_of_byte mismatch, expected %0b, got %0b",
                                 $time, exp_r.eob, last_of_byte);
                        error_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic first);
        adpcm_byte_t item;
        item.data = b;
        item.first = first;
        pending_bytes_q.insert(pending_bytes_q.size(), item);
        bytes_outstanding++;
    endtask

    // Tracks with random content, plus a few stray track starts.
    task automatic queue_random_tracks(input int n_bytes);
        int          left;
        int          len;
        logic [7:0]  b;
        left = n_bytes;
        while (left > 0)
        begin
            len = $urandom_range(12, 1);
            for (int i = 0; i < len && left > 0; i++)
            begin
                case ($urandom_range(3))
                    0: b = 8'h77;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(255));
                endcase
                queue_byte(b, (i == 0) || ($urandom_range(19) == 0));
                left--;
            end
        end
    endtask

    // Block until every byte is accepted and every sample seen, then let it settle.
    task automatic drain_decoder();
        while (bytes_outstanding != 0 || expected_pcm_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_index(input logic [6:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        start_idx = v;
        index_writes++;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 7;
        recv_idle_pct = 69;

        // reset start index: drive to top clamps, then the other way, then every wide code
        queue_byte(8'h77, 1'b1);
        repeat (5) queue_byte(8'h77, 1'b0);
        repeat (3) queue_byte(8'hFF, 1'b0);
        for (int c = 0; c < 16; c += 2)
            queue_byte({4'(c + 1), 4'(c)}, 1'b0);
        drain_decoder();

        // lowest start index: narrow codes, index clamp at zero
        write_start_index(7'd0);
        queue_byte(8'hE4, 1'b1);
        queue_byte(8'h1B, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        drain_decoder();

        // register value above the table saturates on load
        write_start_index(7'd127);
        queue_byte(8'h00, 1'b1);
        queue_random_tracks(24);
        drain_decoder();
        write_start_index(IDX_MAX);
        queue_random_tracks(25);
        drain_decoder();

        send_idle_pct = 69;
        recv_idle_pct = 7;
        write_start_index(IDX_WIDE_MIN - 7'd1);
        queue_random_tracks(25);
        drain_decoder();
        write_start_index(IDX_WIDE_MIN);
        queue_random_tracks(25);
        drain_decoder();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_start_index(7'd80);
        queue_random_tracks(25);
        drain_decoder();
        write_start_index(7'($urandom_range(127)));
        queue_random_tracks(25);
        drain_decoder();

        $display("Decoded %0d bytes into %0d checked samples across %0d start-index writes",
                 bytes_decoded, samples_checked, index_writes);
        $display("Start indexes included 0, 17, 18, 79 and values above the table range");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
